// ----- hw/rtl/terrain_frustum_cull_macros.svh -----
// Assertion macros shared by the terrain frustum cull checkers.
`ifndef TERRAIN_FRUSTUM_CULL_MACROS_SVH
`define TERRAIN_FRUSTUM_CULL_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TFC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tfc_pkg.sv -----
// Shared constants and types for the terrain frustum cull block.
package tfc_pkg;

  localparam int unsigned VTX_W              = 26;
  localparam int unsigned TRI_W              = 27;
  localparam int unsigned NUM_PLANES         = 6;
  localparam int unsigned PLANE_W            = 64;
  localparam int unsigned COEF_W             = 16;
  localparam int unsigned GW_W               = 11;
  localparam int unsigned GR_W               = 16;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned GRID_MAX_WIDTH_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd7;

  typedef struct packed {
    logic [VTX_W-1:0] v;
    logic [VTX_W-1:0] w;
    logic             t_upper;
    logic             t_lower;
    logic             pass_end;
  } rec_t;

endpackage

// ----- hw/rtl/tfc_if.sv -----
// Vertex and triangle channel interfaces.
interface tfc_vtx_if import tfc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface tfc_tri_if import tfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] corner_a;
  logic [VTX_W-1:0] corner_b;
  logic [VTX_W-1:0] corner_c;
  logic [TRI_W-1:0] slot;
  logic             last;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output slot, output last, input ready);
  modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                  input slot, input last, output ready);
endinterface

// ----- hw/rtl/terrain_frustum_cull.sv -----
// Top level of the terrain frustum cull block.
// Throughput: one vertex per cycle through the plane test pipeline unless a record waits
// on a full queue; the back end sends one triangle per cycle while the output is ready.
// Reset: asynchronous active low; clears counters, flags, queue and output valid,
// and sets the planes to zero and the grid to two by two. The line store is not cleared.
module terrain_frustum_cull import tfc_pkg::*; #(
  parameter int unsigned GRID_MAX_WIDTH = GRID_MAX_WIDTH_DEF,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tfc_vtx_if.sink              vtx_i,
  tfc_tri_if.source            tri_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PLANE_W-1:0]   cfg_data_i
);

  logic q_push, q_full, q_vld, q_pop;
  rec_t q_in, q_out;

  tfc_front #(
    .GRID_MAX_WIDTH (GRID_MAX_WIDTH),
    .COORD_BITS     (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_i      (vtx_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_rec_o    (q_in)
  );

  tfc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .rec_i  (q_in),
    .full_o (q_full),
    .vld_o  (q_vld),
    .rec_o  (q_out),
    .pop_i  (q_pop)
  );

  tfc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_vld_i (q_vld),
    .q_rec_i (q_out),
    .q_pop_o (q_pop),
    .tri_o   (tri_o)
  );

endmodule

// ----- hw/rtl/tfc_queue.sv -----
// Short record queue between the classify front and the triangle back end.
module tfc_queue import tfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  output logic vld_o,
  output rec_t rec_o,
  input  logic pop_i
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  rec_t          mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;
  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(QUEUE_DEPTH-1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(QUEUE_DEPTH-1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

// ----- hw/rtl/tfc_front.sv -----
// Front end: configuration, plane test pipeline, line store and quad classification.
module tfc_front import tfc_pkg::*; #(
  parameter int unsigned GRID_MAX_WIDTH = GRID_MAX_WIDTH_DEF,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tfc_vtx_if.sink              vtx_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PLANE_W-1:0]   cfg_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output rec_t                 q_rec_o
);

  localparam int unsigned CW = (GRID_MAX_WIDTH > 2) ? $clog2(GRID_MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(GRID_MAX_WIDTH + 1);
  localparam int unsigned PW = COEF_W + COORD_BITS;
  localparam int unsigned DW = 30;
  localparam int unsigned SW = ((PW > DW) ? PW : DW) + 2;

  typedef struct packed {
    logic [CW-1:0]    col;
    logic             col_nz;
    logic             row_nz;
    logic [VTX_W-1:0] v;
    logic [VTX_W-1:0] w;
    logic             pass_end;
  } ctx_t;

  logic [PLANE_W-1:0] plane_q [NUM_PLANES];
  logic [GW_W-1:0]    gw_q;
  logic [GR_W-1:0]    gr_q;

  logic [WW-1:0]      w_eff;
  logic [GR_W-1:0]    r_eff;
  logic [CW-1:0]      col_q;
  logic [GR_W-1:0]    row_q;
  logic [VTX_W-1:0]   vnum_q;
  logic               col_end, row_end;
  logic               adv, accept;
  ctx_t               ctx_d;

  logic                         s1_vld_q, s2_vld_q, s3_vld_q;
  ctx_t                         s1_ctx_q, s2_ctx_q, s3_ctx_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic signed [PW-1:0]         prod_d [NUM_PLANES][3];
  logic signed [PW-1:0]         prod_q [NUM_PLANES][3];
  logic signed [SW-1:0]         ab_d [NUM_PLANES];
  logic signed [SW-1:0]         cd_d [NUM_PLANES];
  logic signed [SW-1:0]         ab_q [NUM_PLANES];
  logic signed [SW-1:0]         cd_q [NUM_PLANES];

  logic line_mem [GRID_MAX_WIDTH];
  logic line_rd_q;
  logic left_q, diag_q;
  logic here, up, t_upper, t_lower, consume;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_q[i] <= '0;
      end
      gw_q <= GW_W'(2);
      gr_q <= GR_W'(2);
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= REG_PLANE_LAST) begin
        plane_q[cfg_idx_i] <= cfg_data_i;
      end else if (cfg_idx_i == REG_GRID_WIDTH) begin
        gw_q <= cfg_data_i[GW_W-1:0];
      end else if (cfg_idx_i == REG_GRID_ROWS) begin
        gr_q <= cfg_data_i[GR_W-1:0];
      end
    end
  end

  always_comb begin
    if (gw_q < GW_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(gw_q) > GRID_MAX_WIDTH) begin
      w_eff = WW'(GRID_MAX_WIDTH);
    end else begin
      w_eff = WW'(gw_q);
    end
    r_eff = (gr_q < GR_W'(2)) ? GR_W'(2) : gr_q;
  end

  assign col_end = (WW'(col_q) + WW'(1)) >= w_eff;
  assign row_end = ({1'b0, row_q} + (GR_W+1)'(1)) >= {1'b0, r_eff};

  assign adv         = !s3_vld_q || !q_full_i;
  assign vtx_i.ready = adv;
  assign accept      = vtx_i.valid && adv;

  always_comb begin
    ctx_d.col      = col_q;
    ctx_d.col_nz   = (col_q != '0);
    ctx_d.row_nz   = (row_q != '0);
    ctx_d.v        = vnum_q;
    ctx_d.w        = VTX_W'(w_eff);
    ctx_d.pass_end = col_end && row_end;
  end

  // raster position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      vnum_q <= '0;
    end else if (accept) begin
      vnum_q <= (col_end && row_end) ? '0 : vnum_q + VTX_W'(1);
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + GR_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // plane products and partial sums
  always_comb begin
    logic signed [COEF_W-1:0] ca, cb, cc, cdd;
    for (int i = 0; i < NUM_PLANES; i++) begin
      ca  = signed'(plane_q[i][15:0]);
      cb  = signed'(plane_q[i][31:16]);
      cc  = signed'(plane_q[i][47:32]);
      cdd = signed'(plane_q[i][63:48]);
      prod_d[i][0] = ca * s1_x_q;
      prod_d[i][1] = cb * s1_y_q;
      prod_d[i][2] = cc * s1_z_q;
      ab_d[i] = SW'(prod_q[i][0]) + SW'(prod_q[i][1]);
      cd_d[i] = SW'(prod_q[i][2]) + (SW'(cdd) <<< 14);
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    logic                 outside;
    outside = 1'b0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      s = ab_q[i] + cd_q[i];
      if (!s[SW-1] && (s != '0)) begin
        outside = 1'b1;
      end
    end
    here = !outside;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctx_q <= ctx_d;
      s1_x_q   <= vtx_i.pos_x;
      s1_y_q   <= vtx_i.pos_y;
      s1_z_q   <= vtx_i.pos_z;
      s2_ctx_q <= s1_ctx_q;
      s3_ctx_q <= s2_ctx_q;
      for (int i = 0; i < NUM_PLANES; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][k] <= prod_d[i][k];
        end
        ab_q[i] <= ab_d[i];
        cd_q[i] <= cd_d[i];
      end
    end
  end

  // previous-row flags
  assign consume = adv && s3_vld_q;

  always_ff @(posedge clk_i) begin
    if (consume) begin
      line_mem[s3_ctx_q.col] <= here;
    end
    if (adv) begin
      line_rd_q <= line_mem[s2_ctx_q.col];
    end
  end

  assign up = line_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 1'b0;
      diag_q <= 1'b0;
    end else if (consume) begin
      left_q <= s3_ctx_q.pass_end ? 1'b0 : here;
      diag_q <= s3_ctx_q.pass_end ? 1'b0 : up;
    end
  end

  assign t_upper = s3_ctx_q.col_nz && s3_ctx_q.row_nz && (left_q || here || up);
  assign t_lower = s3_ctx_q.col_nz && s3_ctx_q.row_nz && (left_q || up || diag_q);

  assign q_push_o         = consume && (t_upper || t_lower || s3_ctx_q.pass_end);
  assign q_rec_o.v        = s3_ctx_q.v;
  assign q_rec_o.w        = s3_ctx_q.w;
  assign q_rec_o.t_upper  = t_upper;
  assign q_rec_o.t_lower  = t_lower;
  assign q_rec_o.pass_end = s3_ctx_q.pass_end;

endmodule

// ----- hw/rtl/tfc_back.sv -----
// Back end: expands queued quad records into triangles with running slot numbers.
module tfc_back import tfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_vld_i,
  input  rec_t      q_rec_i,
  output logic      q_pop_o,
  tfc_tri_if.source tri_o
);

  typedef enum logic [1:0] {
    PH_UPPER = 2'b01,
    PH_LOWER = 2'b10
  } phase_e;

  phase_e           ph_q, ph_d;
  logic             out_vld_q;
  logic [VTX_W-1:0] ca_q, cb_q, cc_q;
  logic [TRI_W-1:0] slot_q;
  logic             last_q;
  logic [TRI_W-1:0] cnt_q, cnt_d;
  logic             load, emit, sel_lower, last_d;
  logic [VTX_W-1:0] vm1, vmw, vmw1;

  assign load = !out_vld_q || tri_o.ready;

  always_comb begin
    ph_d      = ph_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    sel_lower = 1'b0;
    last_d    = 1'b0;
    if (load && q_vld_i) begin
      case (ph_q)
        PH_UPPER: begin
          if (q_rec_i.t_upper) begin
            emit   = 1'b1;
            last_d = !q_rec_i.t_lower;
            if (q_rec_i.t_lower) begin
              ph_d = PH_LOWER;
            end else begin
              q_pop_o = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            if (q_rec_i.t_lower) begin
              emit      = 1'b1;
              sel_lower = 1'b1;
              last_d    = 1'b1;
            end
          end
        end
        PH_LOWER: begin
          emit      = 1'b1;
          sel_lower = 1'b1;
          last_d    = 1'b1;
          q_pop_o   = 1'b1;
          ph_d      = PH_UPPER;
        end
        default: begin
          ph_d = PH_UPPER;
        end
      endcase
    end
    cnt_d = emit ? cnt_q + TRI_W'(1) : cnt_q;
    if (q_pop_o && q_rec_i.pass_end) begin
      cnt_d = '0;
    end
  end

  assign vm1  = q_rec_i.v - VTX_W'(1);
  assign vmw  = q_rec_i.v - q_rec_i.w;
  assign vmw1 = vmw - VTX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_UPPER;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      if (load) begin
        out_vld_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ca_q   <= vm1;
      cb_q   <= sel_lower ? vmw : q_rec_i.v;
      cc_q   <= sel_lower ? vmw1 : vmw;
      slot_q <= cnt_q;
      last_q <= last_d;
    end
  end

  assign tri_o.valid    = out_vld_q;
  assign tri_o.corner_a = ca_q;
  assign tri_o.corner_b = cb_q;
  assign tri_o.corner_c = cc_q;
  assign tri_o.slot     = slot_q;
  assign tri_o.last     = last_q;

endmodule

// ----- hw/rtl/tfc_checker.sv -----
// Port-level assertions for the terrain frustum cull block, bound to the top level.
`include "terrain_frustum_cull_macros.svh"

module tfc_props import tfc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VTX_W-1:0] corner_a_i,
  input logic [VTX_W-1:0] corner_b_i,
  input logic [TRI_W-1:0] slot_i,
  input logic             last_i
);

  `TFC_ASSERT_NEXT(a_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "valid dropped")
  `TFC_ASSERT_NEXT(a_data_hold, out_valid_i && !out_ready_i,
                   $stable(corner_a_i) && $stable(slot_i) && $stable(last_i), "payload changed")
  `TFC_ASSERT(a_upper_shape,
              !(out_valid_i && !last_i) || (VTX_W'(corner_b_i - corner_a_i) == VTX_W'(1)),
              "bad upper triangle")
  `TFC_ASSERT_NEXT(a_pair_slot, out_valid_i && out_ready_i && !last_i,
                   out_valid_i && (slot_i == TRI_W'($past(slot_i) + TRI_W'(1))), "pair broken")

endmodule

bind terrain_frustum_cull tfc_props u_tfc_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (tri_o.valid),
  .out_ready_i (tri_o.ready),
  .corner_a_i  (tri_o.corner_a),
  .corner_b_i  (tri_o.corner_b),
  .slot_i      (tri_o.slot),
  .last_i      (tri_o.last)
);
